@@ rtl/core/fmmp_pkg.sv @@
// Shared types, constants and microcode encodings for the Fibonacci matrix-power block.
// No dependencies.
package fmmp_pkg;

  localparam int IDX_W        = 63;
  localparam int FIB_W        = 31;
  localparam int MOD_W        = 31;
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 32;
  localparam int EXP_BITS_DEF = 63;
  localparam int PROD_W       = 2 * MOD_W;
  localparam int ACC_W        = PROD_W + 1;
  localparam int RED_W        = 64;
  localparam int RED_RADIX    = 4;
  localparam int RED_STEPS    = RED_W / RED_RADIX;
  localparam int RED_CNT_W    = $clog2(RED_STEPS);
  localparam int UPC_W        = 4;
  localparam int UROM_DEPTH   = 1 << UPC_W;

  localparam logic [MOD_W-1:0] MODULUS_RST = 31'd1000000007;

  // datapath operations
  localparam logic [3:0] OP_NOP    = 4'd0;
  localparam logic [3:0] OP_MUL_XX = 4'd1;
  localparam logic [3:0] OP_MUL_YY = 4'd2;
  localparam logic [3:0] OP_ACC    = 4'd3;
  localparam logic [3:0] OP_RED    = 4'd4;
  localparam logic [3:0] OP_SAVE_T = 4'd5;
  localparam logic [3:0] OP_SUM_S  = 4'd6;
  localparam logic [3:0] OP_MUL_YS = 4'd7;
  localparam logic [3:0] OP_LD_P   = 4'd8;
  localparam logic [3:0] OP_SQ_WB  = 4'd9;
  localparam logic [3:0] OP_QSTEP  = 4'd10;
  localparam logic [3:0] OP_SHIFT  = 4'd11;

  // sequencer conditions
  localparam logic [1:0] C_NEXT = 2'd0;
  localparam logic [1:0] C_WAIT = 2'd1;
  localparam logic [1:0] C_LOOP = 2'd2;
  localparam logic [1:0] C_END  = 2'd3;

  typedef struct packed {
    logic [3:0]       op;
    logic [1:0]       cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic       load;
    logic [3:0] op;
  } dp_ctrl_t;

  typedef struct packed {
    logic red_busy;
    logic last_bit;
  } dp_stat_t;

endpackage

@@ rtl/core/fmmp_modred.sv @@
// Iterative modular reduction: 64-bit value mod a 31-bit modulus, 4 bits a cycle.
// Depends on fmmp_pkg.
module fmmp_modred import fmmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RED_W-1:0] value,
  input  logic [MOD_W-1:0] modulus,
  output logic             busy,
  output logic [MOD_W-1:0] rem
);

  logic                 busy_r, busy_nxt;
  logic [RED_W-1:0]     sh_r, sh_nxt;
  logic [MOD_W-1:0]     rem_r, rem_nxt;
  logic [RED_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W:0]       part;
  logic [MOD_W-1:0]     r;

  // restoring remainder over one radix-16 digit
  always_comb begin
    r = rem_r;
    for (int k = 0; k < RED_RADIX; k++) begin
      part = {r, sh_r[RED_W-1-k]};
      if (part >= {1'b0, modulus}) begin
        part = part - {1'b0, modulus};
      end
      r = part[MOD_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      sh_nxt   = value;
      rem_nxt  = '0;
      cnt_nxt  = RED_CNT_W'(RED_STEPS - 1);
    end else if (busy_r) begin
      sh_nxt  = sh_r << RED_RADIX;
      rem_nxt = r;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/fmmp_datapath.sv @@
// Datapath: matrix entries, shared 31x31 multiplier, accumulator, exponent shifter.
// Depends on fmmp_pkg and fmmp_modred.
module fmmp_datapath import fmmp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_ctrl_t         ctrl,
  input  logic [IDX_W-1:0] index,
  input  logic [MOD_W-1:0] modulus,
  output dp_stat_t         stat,
  output logic [FIB_W-1:0] fib
);

  localparam int BCNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  // Q^k is symmetric, so only top-left (x) and off-diagonal (y) are kept;
  // bottom-right is x - y.
  logic [MOD_W-1:0]    x_r, y_r, t_r, s_r;
  logic [PROD_W-1:0]   mul_r;
  logic [ACC_W-1:0]    p_r;
  logic [EXP_BITS-1:0] e_r;
  logic [BCNT_W-1:0]   bcnt_r;
  logic [MOD_W-1:0]    mul_a, mul_b;
  logic [RED_W-1:0]    idx_ext;
  logic                red_busy;
  logic [MOD_W-1:0]    red_rem;

  function automatic logic [MOD_W-1:0] addmod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_W-1:0];
  endfunction

  function automatic logic [MOD_W-1:0] submod(input logic [MOD_W-1:0] a,
                                               input logic [MOD_W-1:0] b,
                                               input logic [MOD_W-1:0] m);
    logic [MOD_W:0] d;
    if (a >= b) begin
      d = {1'b0, a} - {1'b0, b};
    end else begin
      d = {1'b0, a} + {1'b0, m} - {1'b0, b};
    end
    return d[MOD_W-1:0];
  endfunction

  assign idx_ext = RED_W'(index);

  always_comb begin
    mul_a = y_r;
    mul_b = s_r;
    unique case (ctrl.op)
      OP_MUL_XX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      OP_MUL_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = y_r;
        mul_b = s_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r    <= MOD_W'(1);
      y_r    <= '0;
      e_r    <= idx_ext[EXP_BITS-1:0];
      bcnt_r <= BCNT_W'(EXP_BITS - 1);
    end else begin
      unique case (ctrl.op) inside
        OP_MUL_XX, OP_MUL_YS: begin
          mul_r <= {{MOD_W{1'b0}}, mul_a} * {{MOD_W{1'b0}}, mul_b};
        end
        OP_MUL_YY: begin
          p_r   <= ACC_W'(mul_r);
          mul_r <= {{MOD_W{1'b0}}, mul_a} * {{MOD_W{1'b0}}, mul_b};
        end
        OP_ACC:    p_r <= p_r + ACC_W'(mul_r);
        OP_LD_P:   p_r <= ACC_W'(mul_r);
        OP_SAVE_T: begin
          t_r <= red_rem;
          s_r <= submod(x_r, y_r, modulus);
        end
        OP_SUM_S:  s_r <= addmod(x_r, s_r, modulus);
        OP_SQ_WB: begin
          x_r <= t_r;
          y_r <= red_rem;
        end
        OP_QSTEP: begin
          if (e_r[EXP_BITS-1]) begin
            x_r <= addmod(x_r, y_r, modulus);
            y_r <= x_r;
          end
        end
        OP_SHIFT: begin
          e_r    <= e_r << 1;
          bcnt_r <= bcnt_r - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  fmmp_modred u_modred (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (!ctrl.load && (ctrl.op == OP_RED)),
    .value   (RED_W'(p_r)),
    .modulus (modulus),
    .busy    (red_busy),
    .rem     (red_rem)
  );

  assign stat.red_busy = red_busy;
  assign stat.last_bit = (bcnt_r == '0);
  assign fib           = y_r;

endmodule

@@ rtl/core/fmmp_useq.sv @@
// Microcode sequencer: program counter, control-word table and jump logic.
// Depends on fmmp_pkg.
module fmmp_useq import fmmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     go,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl,
  output logic     busy,
  output logic     done
);

  // one exponent bit: square via x' = x^2 + y^2, y' = y(2x - y), then
  // optional multiply by Q, then shift the exponent
  localparam uword_t UROM [UROM_DEPTH] = '{
    '{OP_MUL_XX, C_NEXT, UPC_W'(0)},
    '{OP_MUL_YY, C_NEXT, UPC_W'(0)},
    '{OP_ACC,    C_NEXT, UPC_W'(0)},
    '{OP_RED,    C_NEXT, UPC_W'(0)},
    '{OP_NOP,    C_WAIT, UPC_W'(0)},
    '{OP_SAVE_T, C_NEXT, UPC_W'(0)},
    '{OP_SUM_S,  C_NEXT, UPC_W'(0)},
    '{OP_MUL_YS, C_NEXT, UPC_W'(0)},
    '{OP_LD_P,   C_NEXT, UPC_W'(0)},
    '{OP_RED,    C_NEXT, UPC_W'(0)},
    '{OP_NOP,    C_WAIT, UPC_W'(0)},
    '{OP_SQ_WB,  C_NEXT, UPC_W'(0)},
    '{OP_QSTEP,  C_NEXT, UPC_W'(0)},
    '{OP_SHIFT,  C_LOOP, UPC_W'(0)},
    '{OP_NOP,    C_END,  UPC_W'(0)},
    '{OP_NOP,    C_END,  UPC_W'(0)}
  };

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] pc_r, pc_nxt;
  uword_t           uw;

  assign uw = UROM[pc_r];

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else begin
      unique case (uw.cond)
        C_NEXT: pc_nxt = pc_r + 1'b1;
        C_WAIT: begin
          if (!stat.red_busy) begin
            pc_nxt = pc_r + 1'b1;
          end
        end
        C_LOOP: begin
          if (stat.last_bit) begin
            pc_nxt = pc_r + 1'b1;
          end else begin
            pc_nxt = uw.target;
          end
        end
        C_END: begin
          if (out_free) begin
            busy_nxt = 1'b0;
          end
        end
        default: pc_nxt = pc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign ctrl.load = go && !busy_r;
  assign ctrl.op   = busy_r ? uw.op : OP_NOP;
  assign busy      = busy_r;
  assign done      = busy_r && (uw.cond == C_END) && out_free;

endmodule

@@ rtl/core/fibonacci_mod_matrix_power.sv @@
// Fibonacci number F(n) mod a programmable modulus, by square-and-multiply
// on the 2x2 matrix [[1,1],[1,0]]. Top level: handshake, modulus register,
// result register. Depends on fmmp_pkg, fmmp_useq and fmmp_datapath.
//
// One index per transaction goes in, one F(index) mod modulus comes out.
// Only the low EXP_BITS bits of the index count. A modulus of 0 or 1 gives 0.
// The block works on one index at a time: in_tready is low from acceptance
// until the result is handed to the output register, which then holds it
// while the next index is already being taken. Each exponent bit costs two
// modular reductions on the shared 4-bit-per-cycle remainder unit, plus 12
// microcode steps around the single 31x31 multiplier. The modulus must only
// be written while the block is idle.
module fibonacci_mod_matrix_power import fmmp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: [62:0] index, [63] zero fill
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [30:0] fib_value, [31] zero fill
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // modulus register
  input  logic                   cfg_wr_en,
  input  logic [MOD_W-1:0]       cfg_wr_data
);

  logic [MOD_W-1:0] modulus_r;
  logic             out_valid_r, out_valid_nxt;
  logic [FIB_W-1:0] out_fib_r;
  logic             in_accept;
  logic             out_free;
  logic             seq_busy;
  logic             seq_done;
  logic             mod_degen;
  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  logic [FIB_W-1:0] dp_fib;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = !seq_busy;
  // result register is free if empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  // modulus 0 or 1: every residue is zero
  assign mod_degen = (modulus_r[MOD_W-1:1] == '0);

  fmmp_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (in_accept),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .busy     (seq_busy),
    .done     (seq_done)
  );

  fmmp_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .index   (in_tdata[IDX_W-1:0]),
    .modulus (modulus_r),
    .stat    (stat),
    .fib     (dp_fib)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MODULUS_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (seq_done) begin
      out_fib_r <= mod_degen ? '0 : dp_fib;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_fib_r);

  // an accepted transaction starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> seq_busy)
    else $error("sequencer did not start on accepted transaction");

  // a finished result never overwrites one still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // a finished item always shows up on the output
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |=> (out_tvalid && !seq_busy))
    else $error("result not presented after completion");

  // the remainder unit only runs under the sequencer
  a_red_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    stat.red_busy |-> seq_busy)
    else $error("reduction running outside a sequence");

endmodule

@@ verif/fmmp_fib_checker.sv @@
// Checker for fibonacci_mod_matrix_power: watches the index, result and modulus ports,
// predicts F(index) mod modulus and compares each result transaction in order.
// Depends on fmmp_pkg.
module fmmp_fib_checker import fmmp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [MOD_W-1:0]       cfg_wr_data,
  output int                     mismatches,
  output int                     fibs_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    bit [IDX_W-1:0] index;
    bit [MOD_W-1:0] modulus;
    bit [FIB_W-1:0] fib_value;
  } fib_due_t;

  fib_due_t       due_fib_q[$];
  bit [MOD_W-1:0] modulus_copy = MODULUS_RST;
  int             fails = 0;

  // Q^n by square-and-multiply, MSB first; F(n) is the top-right entry
  function automatic bit [FIB_W-1:0] fib_mod(bit [IDX_W-1:0] n, bit [MOD_W-1:0] m);
    bit [63:0] mm, a00, a01, a10, a11, t00, t01, t10, t11;
    bit        nb;
    if (m < 2) return '0;
    mm  = 64'(m);
    a00 = 1; a01 = 0; a10 = 0; a11 = 1;
    for (int b = EXP_BITS - 1; b >= 0; b--) begin
      t00 = ((a00 * a00) % mm + (a01 * a10) % mm) % mm;
      t01 = ((a00 * a01) % mm + (a01 * a11) % mm) % mm;
      t10 = ((a10 * a00) % mm + (a11 * a10) % mm) % mm;
      t11 = ((a10 * a01) % mm + (a11 * a11) % mm) % mm;
      nb  = (b < IDX_W) ? n[b] : 1'b0;
      if (nb) begin
        // times [[1,1],[1,0]]
        a00 = (t00 + t01) % mm; a01 = t00;
        a10 = (t10 + t11) % mm; a11 = t10;
      end else begin
        a00 = t00; a01 = t01; a10 = t10; a11 = t11;
      end
    end
    return a01[FIB_W-1:0];
  endfunction

  always @(posedge clk) begin : track
    fib_due_t       due;
    bit [FIB_W-1:0] got;
    if (!rst_n) begin
      modulus_copy = MODULUS_RST;
      due_fib_q.delete();
    end else begin
      if (cfg_wr_en) modulus_copy = cfg_wr_data;
      // results first, so an index taken on the same edge cannot be matched
      if (out_tvalid && out_tready) begin
        got = out_tdata[FIB_W-1:0];
        if (due_fib_q.size() == 0) begin
          $error("fib_value: expected none, got %0d", got);
          fails++;
        end else begin
          due = due_fib_q.pop_front();
          if (got !== due.fib_value) begin
            $error("fib_value: expected %0d, got %0d (index %0d, modulus %0d)",
                   due.fib_value, got, due.index, due.modulus);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        due.index     = in_tdata[IDX_W-1:0];
        due.modulus   = modulus_copy;
        due.fib_value = fib_mod(due.index, modulus_copy);
        due_fib_q.push_back(due);
      end
    end
    mismatches <= fails;
    fibs_due   <= due_fib_q.size();
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for fibonacci_mod_matrix_power: drives index transactions and modulus
// writes, throttles the result side, and gives the verdict. Depends on fmmp_pkg,
// fmmp_fib_checker and the block's RTL.
module tb_top import fmmp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 46 * EXP_BITS_DEF + 2;  // per index
  localparam int HOLD_CYCLES = 6500;                   // long result-side hold-off
  localparam int HOLD_AFTER  = 40;                     // results seen before the hold-off
  localparam int STALL_LIMIT = 40000;                  // cycles with no transaction at all
  localparam int PHASE_ITEMS = 70;

  localparam bit [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en;
  logic [MOD_W-1:0]       cfg_wr_data;

  int mismatches;
  int fibs_due;
  int results_seen = 0;
  bit calm = 1'b0;  // no idling on either side in the closing phase

  fibonacci_mod_matrix_power dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  fmmp_fib_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .fibs_due   (fibs_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) results_seen <= results_seen + 1;
  end

  // Index mix: full-width, small n, around powers of two, and random widths.
  function automatic bit [IDX_W-1:0] pick_index();
    bit [63:0] r;
    int        k;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return r[IDX_W-1:0];
      1: return IDX_W'($urandom_range(0, 200));
      2: begin
        k = $urandom_range(0, IDX_W - 1);
        return (IDX_W'(1) << k) + IDX_W'($urandom_range(0, 2)) - IDX_W'(1);
      end
      default: return r[IDX_W-1:0] >> $urandom_range(0, IDX_W - 1);
    endcase
  endfunction

  // One index transaction; in_tvalid stays high afterwards unless a gap comes next.
  task automatic send_index(input bit [IDX_W-1:0] idx);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(idx);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Block is idle once every predicted result has been taken.
  task automatic wait_drained();
    do @(posedge clk); while (fibs_due != 0);
  endtask

  task automatic write_modulus(input bit [MOD_W-1:0] m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input bit [MOD_W-1:0] m, input int count);
    wait_drained();
    write_modulus(m);
    repeat (count) send_index(pick_index());
    in_tvalid <= 1'b0;
  endtask

  // Result side: short random stalls, plus one long hold-off so that the block
  // parks a result, takes the next index and then backs up its input.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: any transaction or register write restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    bit [IDX_W-1:0] corners[14];
    bit [IDX_W-1:0] idx_max;
    idx_max = {IDX_W{1'b1}};
    corners = '{
      IDX_W'(0), IDX_W'(1), IDX_W'(2), IDX_W'(3), IDX_W'(12),
      IDX_W'(46), IDX_W'(47), IDX_W'(93),
      idx_max,                                // all exponent bits set
      IDX_W'(1) << (IDX_W - 1),               // top bit only
      IDX_W'({(IDX_W + 1) / 2{2'b01}}),       // alternating bits, both phases
      IDX_W'({(IDX_W + 1) / 2{2'b10}}),
      IDX_W'(1000000006), IDX_W'(2000000016)
    };

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corner indexes at the reset modulus
    foreach (corners[i]) send_index(corners[i]);
    in_tvalid <= 1'b0;

    // modulus zero and one both give zero whatever the index
    wait_drained();
    write_modulus(MOD_W'(0));
    send_index(IDX_W'(0));
    send_index(IDX_W'(1));
    send_index(idx_max);
    in_tvalid <= 1'b0;
    wait_drained();
    write_modulus(MOD_W'(1));
    send_index(IDX_W'(1));
    send_index(IDX_W'(7));
    send_index(idx_max);
    in_tvalid <= 1'b0;

    // random phases over a spread of moduli, extremes included
    run_phase(MOD_MAX, PHASE_ITEMS);
    run_phase(MOD_W'(2), PHASE_ITEMS);
    run_phase(MOD_W'($urandom), PHASE_ITEMS);
    run_phase(MOD_W'(3), PHASE_ITEMS);
    run_phase(MOD_W'($urandom_range(2, 1000)), PHASE_ITEMS);
    run_phase(MODULUS_RST, PHASE_ITEMS);
    run_phase(MOD_W'($urandom_range(1 << 30, 32'(MOD_MAX))), PHASE_ITEMS);
    calm = 1'b1;
    run_phase(MOD_W'($urandom), PHASE_ITEMS);

    wait_drained();
    repeat (LATENCY + 100) @(posedge clk);
    if (mismatches == 0 && fibs_due == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/fmmp_pkg.sv
rtl/core/fmmp_modred.sv
rtl/core/fmmp_datapath.sv
rtl/core/fmmp_useq.sv
rtl/core/fibonacci_mod_matrix_power.sv
verif/fmmp_fib_checker.sv
verif/tb_top.sv
